// File: design/ipv4hb_pkg.sv
// ----------------------------------------------------------------------------
// ipv4hb_pkg
// Types and constants shared by the IPv4 header builder modules.
// ----------------------------------------------------------------------------
package ipv4hb_pkg;

  localparam int unsigned HdrWords = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0]  VerIhl      = 8'h45;
  localparam logic [16:0] HdrBytes    = 17'd20;
  localparam logic [7:0]  TtlReset    = 8'd64;
  localparam logic [15:0] IdBaseReset = 16'd1234;

  typedef logic [2:0] word_idx_t;

  localparam word_idx_t WdVerLen   = 3'd0;
  localparam word_idx_t WdIdent    = 3'd1;
  localparam word_idx_t WdTtlCsum  = 3'd2;
  localparam word_idx_t WdSrc      = 3'd3;
  localparam word_idx_t WdDst      = 3'd4;

  typedef enum logic [0:0] {
    CFG_TTL     = 1'b0,
    CFG_ID_BASE = 1'b1
  } cfg_reg_e;

  typedef logic [0:0]  cfg_idx_t;
  typedef logic [15:0] cfg_data_t;

  // One header as it travels from the front end to the word sequencer.
  typedef struct packed {
    logic [15:0] total_len;
    logic        len_ovf;
    logic [15:0] ident;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [15:0] checksum;
    logic [31:0] src;
    logic [31:0] dst;
  } hdr_t;

endpackage

// File: design/ipv4hb_if.sv
// ----------------------------------------------------------------------------
// ipv4hb_req_if / ipv4hb_word_if
// Valid/ready channels for header requests and header words.
// ----------------------------------------------------------------------------
interface ipv4hb_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_length;
  logic [7:0]  protocol;
  logic [31:0] source_addr;
  logic [31:0] dest_addr;

  modport source (
    output valid, payload_length, protocol, source_addr, dest_addr,
    input  ready
  );
  modport sink (
    input  valid, payload_length, protocol, source_addr, dest_addr,
    output ready
  );
endinterface

interface ipv4hb_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        length_overflow;

  modport source (
    output valid, header_word, word_index, last_word, length_overflow,
    input  ready
  );
  modport sink (
    input  valid, header_word, word_index, last_word, length_overflow,
    output ready
  );
endinterface

// File: design/ipv4hb_front.sv
// ----------------------------------------------------------------------------
// ipv4hb_front
// Accepts requests, fills in the header fields and the checksum, and pushes
// the finished header into the queue.
// ----------------------------------------------------------------------------
module ipv4hb_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  ipv4hb_pkg::cfg_idx_t  cfg_idx_i,
  input  ipv4hb_pkg::cfg_data_t cfg_data_i,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic [15:0]          payload_length_i,
  input  logic [7:0]           protocol_i,
  input  logic [31:0]          source_addr_i,
  input  logic [31:0]          dest_addr_i,
  output logic                 push_o,
  output ipv4hb_pkg::hdr_t      push_hdr_o,
  input  logic                 full_i
);
  import ipv4hb_pkg::*;

  logic [7:0]  ttl_q, ttl_d;
  logic [15:0] id_base_q, id_base_d;
  logic [15:0] pkt_cnt_q, pkt_cnt_d;
  logic        stg_valid_q, stg_valid_d;
  hdr_t        stg_q, stg_d;
  logic        accept;
  logic [16:0] total;
  logic [18:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;

  assign req_ready_o = !stg_valid_q || !full_i;
  assign accept      = req_valid_i && req_ready_o;
  assign push_o      = stg_valid_q && !full_i;

  always_comb begin
    ttl_d     = ttl_q;
    id_base_d = id_base_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_TTL:     ttl_d     = cfg_data_i[7:0];
        CFG_ID_BASE: id_base_d = cfg_data_i;
        default:     ;
      endcase
    end
  end

  always_comb begin
    total                 = {1'b0, payload_length_i} + HdrBytes;
    stg_d                 = stg_q;
    stg_valid_d           = stg_valid_q;
    pkt_cnt_d             = pkt_cnt_q;
    if (push_o) begin
      stg_valid_d = 1'b0;
    end
    if (accept) begin
      stg_valid_d        = 1'b1;
      stg_d.total_len    = total[15:0];
      stg_d.len_ovf      = total[16];
      stg_d.ident        = id_base_q + pkt_cnt_q;
      stg_d.ttl          = ttl_q;
      stg_d.protocol     = protocol_i;
      stg_d.checksum     = '0;
      stg_d.src          = source_addr_i;
      stg_d.dst          = dest_addr_i;
      pkt_cnt_d          = pkt_cnt_q + 16'd1;
    end
  end

  // Ones'-complement sum of the ten header halfwords, checksum field as zero.
  always_comb begin
    sum = 19'({VerIhl, 8'h00}) + 19'(stg_q.total_len) + 19'(stg_q.ident)
        + 19'({stg_q.ttl, stg_q.protocol})
        + 19'(stg_q.src[31:16]) + 19'(stg_q.src[15:0])
        + 19'(stg_q.dst[31:16]) + 19'(stg_q.dst[15:0]);
    fold1 = 17'(sum[18:16]) + 17'(sum[15:0]);
    fold2 = fold1[15:0] + 16'(fold1[16]);
    push_hdr_o          = stg_q;
    push_hdr_o.checksum = ~fold2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q       <= TtlReset;
      id_base_q   <= IdBaseReset;
      pkt_cnt_q   <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      ttl_q       <= ttl_d;
      id_base_q   <= id_base_d;
      pkt_cnt_q   <= pkt_cnt_d;
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

endmodule

// File: design/ipv4hb_queue.sv
// ----------------------------------------------------------------------------
// ipv4hb_queue
// Short first-in first-out queue of finished headers.
// ----------------------------------------------------------------------------
module ipv4hb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ipv4hb_pkg::hdr_t push_hdr_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output ipv4hb_pkg::hdr_t head_o
);
  import ipv4hb_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  hdr_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_hdr_i;
    end
  end

endmodule

// File: design/ipv4hb_back.sv
// ----------------------------------------------------------------------------
// ipv4hb_back
// Walks the header at the head of the queue into the output register, one
// word per cycle while the receiver keeps ready high.
// ----------------------------------------------------------------------------
module ipv4hb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  ipv4hb_pkg::hdr_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     header_word_o,
  output logic [2:0]      word_index_o,
  output logic            last_word_o,
  output logic            length_overflow_o
);
  import ipv4hb_pkg::*;

  localparam word_idx_t LastIdx = word_idx_t'(HdrWords - 1);

  word_idx_t   widx_q, widx_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] word_q, word_d;
  word_idx_t   oidx_q;
  logic        last_q;
  logic        ovf_q;
  logic        load;

  assign load  = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && (widx_q == LastIdx);

  always_comb begin
    case (widx_q)
      WdVerLen:  word_d = {VerIhl, 8'h00, head_i.total_len};
      WdIdent:   word_d = {head_i.ident, 16'h0000};
      WdTtlCsum: word_d = {head_i.ttl, head_i.protocol, head_i.checksum};
      WdSrc:     word_d = head_i.src;
      WdDst:     word_d = head_i.dst;
      default:   word_d = '0;
    endcase
  end

  always_comb begin
    widx_d      = widx_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      widx_d      = (widx_q == LastIdx) ? '0 : widx_q + word_idx_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      widx_q      <= widx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
      oidx_q <= widx_q;
      last_q <= (widx_q == LastIdx);
      ovf_q  <= head_i.len_ovf;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign header_word_o     = word_q;
  assign word_index_o      = oidx_q;
  assign last_word_o       = last_q;
  assign length_overflow_o = ovf_q;

endmodule

// File: design/ipv4_header_builder.sv
// ----------------------------------------------------------------------------
// ipv4_header_builder
// Builds a 20-byte IPv4 header with checksum for each request.
// ----------------------------------------------------------------------------
// Usage: each word on the req channel carries a payload length, a protocol
// number and the source and destination addresses. For each one the hdr
// channel delivers five header words in network order, word_index 0 to 4,
// with last_word on the fifth and length_overflow on all five when the
// total length wrapped. TTL and the identification base are set through the
// write port (index 0 and 1) while no request is in flight.
// Flow: an accepted request is registered in the front stage, pushed into
// the header queue and loaded word by word into the output register, whose
// single channel carries one word per cycle while ready is high; a request
// may be accepted in every cycle while the two-entry header queue has room.
// Reset: TTL returns to 64, the identification base to 1234 and the packet
// counter to zero; the queue and the output register are emptied.
// Stall: when the receiver holds ready low the current word stays on the
// port, the queue fills and then req ready drops until space returns.
// ----------------------------------------------------------------------------
module ipv4_header_builder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  ipv4hb_pkg::cfg_idx_t  cfg_idx_i,
  input  ipv4hb_pkg::cfg_data_t cfg_data_i,
  ipv4hb_req_if.sink            req,
  ipv4hb_word_if.source         hdr
);
  import ipv4hb_pkg::*;

  logic push, full, pop, empty;
  hdr_t push_hdr, head;

  ipv4hb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .req_valid_i      (req.valid),
    .req_ready_o      (req.ready),
    .payload_length_i (req.payload_length),
    .protocol_i       (req.protocol),
    .source_addr_i    (req.source_addr),
    .dest_addr_i      (req.dest_addr),
    .push_o           (push),
    .push_hdr_o       (push_hdr),
    .full_i           (full)
  );

  ipv4hb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_hdr_i (push_hdr),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  ipv4hb_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (hdr.valid),
    .out_ready_i       (hdr.ready),
    .header_word_o     (hdr.header_word),
    .word_index_o      (hdr.word_index),
    .last_word_o       (hdr.last_word),
    .length_overflow_o (hdr.length_overflow)
  );

endmodule
